### hdl/rbpgt_pkg.sv
// ----------------------------------------------------------------------------
// Rule-based PID gain tuner package
// Shared types, limits and the constant divider used by the tuner pipeline.
// ----------------------------------------------------------------------------
package rbpgt_pkg;

	// Oscillation count that triggers the kp back-off.
	localparam logic [2:0] FLIP_LIMIT = 3'd4;

	localparam logic [13:0] KP_MIN   = 14'd1229;
	localparam logic [13:0] KP_MAX   = 14'd10240;
	localparam logic [12:0] KI_MAX   = 13'd4915;
	localparam logic [10:0] KD_MAX   = 11'd1638;
	localparam logic [13:0] KP_RESET = 14'd4096;
	localparam logic [12:0] KI_RESET = 13'd2048;
	localparam logic [10:0] KD_RESET = 11'd0;

	localparam logic [15:0] DT_FIRST = 16'd20;
	localparam logic [15:0] DT_MAX   = 16'hFFFF;

	localparam logic signed [15:0] SAT_LEVEL = 16'sd255;
	localparam logic [15:0] DECAY_NUM   = 16'd64225;
	localparam logic [47:0] DECAY_ROUND = 48'd32768;

	// 10 rpm in Q16.8, scaled by 5 for the large-error test.
	localparam logic [26:0] ERR_OFFSET = 27'd12800;

	localparam int CFG_DATA_W = 14;
	localparam int CFG_IDX_W  = 2;

	// Gain increments are floor(n / 1250); the reciprocal is exact for n < 2^29.
	localparam logic [9:0]  RND_1250  = 10'd625;
	localparam int          DIV_SHIFT = 40;
	localparam logic [29:0] DIV_MUL   = 30'(((64'd1 << DIV_SHIFT) + 64'd1249) / 64'd1250);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_START = 2'd0,
		REG_KI_START = 2'd1,
		REG_KD_START = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic                  write;
		cfg_reg_t              index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_t;

	typedef struct packed {
		logic [31:0]        timestamp_ms;
		logic               speed_mode;
		logic signed [23:0] wheel_speed_left;
		logic signed [23:0] wheel_speed_right;
		logic signed [23:0] target_speed;
		logic signed [15:0] drive_left;
		logic signed [15:0] drive_right;
		logic signed [31:0] integral_in;
	} tick_t;

	typedef struct packed {
		logic [13:0]        kp_out;
		logic [12:0]        ki_out;
		logic [10:0]        kd_out;
		logic signed [31:0] integral_out;
		logic [2:0]         flip_count;
	} result_t;

	typedef struct packed {
		logic               tune;
		logic [15:0]        dt;
		logic signed [24:0] err;
		logic [23:0]        sp_mag;
		logic               sat;
		logic               int_neg;
		logic [47:0]        int_prod;
		logic signed [31:0] integral;
	} front_t;

	typedef struct packed {
		logic               tune;
		logic signed [24:0] err;
		logic               big_err;
		logic [17:0]        kp_up;
		logic [15:0]        ki_up;
		logic [18:0]        kp_dn;
		logic [16:0]        kd_up;
		logic signed [31:0] integral;
	} scale_t;

	function automatic logic [18:0] div1250(input logic [28:0] num);
		logic [58:0] prod;
		prod = 59'(num) * 59'(DIV_MUL);
		return prod[DIV_SHIFT +: 19];
	endfunction

endpackage

### hdl/rbpgt_front.sv
// ----------------------------------------------------------------------------
// Tuner front stage
// Forms the tick time, the speed error and the integral decay product.
// ----------------------------------------------------------------------------
module rbpgt_front import rbpgt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  tick_t  in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output front_t out_data
);

	logic [31:0]        last_time_q;
	logic               vld_s2;
	front_t             data_s2;
	front_t             nxt;
	logic [31:0]        delta;
	logic signed [24:0] wsum;
	logic signed [23:0] avg;
	logic [31:0]        int_mag;

	assign in_ready  = ~vld_s2 | out_ready;
	assign out_valid = vld_s2;
	assign out_data  = data_s2;

	always_comb begin
		delta = in_data.timestamp_ms - last_time_q;
		nxt.tune = in_data.speed_mode;
		// A stored time of zero means no tick has been seen yet.
		if (last_time_q == '0 || delta == '0) begin
			nxt.dt = DT_FIRST;
		end else if (delta[31:16] != '0) begin
			nxt.dt = DT_MAX;
		end else begin
			nxt.dt = delta[15:0];
		end

		wsum = {in_data.wheel_speed_left[23], in_data.wheel_speed_left}
			+ {in_data.wheel_speed_right[23], in_data.wheel_speed_right};
		// Dropping the low bit of the sum rounds the average toward minus infinity.
		avg = wsum[24:1];
		nxt.err = {in_data.target_speed[23], in_data.target_speed} - {avg[23], avg};
		nxt.sp_mag = in_data.target_speed[23] ? 24'(-in_data.target_speed)
			: 24'(in_data.target_speed);

		nxt.sat = (in_data.drive_left >= SAT_LEVEL) || (in_data.drive_left <= -SAT_LEVEL)
			|| (in_data.drive_right >= SAT_LEVEL) || (in_data.drive_right <= -SAT_LEVEL);

		int_mag = in_data.integral_in[31] ? 32'(-in_data.integral_in)
			: 32'(in_data.integral_in);
		nxt.int_neg  = in_data.integral_in[31];
		nxt.int_prod = 48'(int_mag) * 48'(DECAY_NUM);
		nxt.integral = in_data.integral_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			vld_s2      <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s2 <= in_valid;
			end
			if (in_valid && in_ready && in_data.speed_mode) begin
				last_time_q <= in_data.timestamp_ms;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= nxt;
		end
	end

endmodule

### hdl/rbpgt_scale.sv
// ----------------------------------------------------------------------------
// Tuner scale stage
// Turns the tick time into gain steps, tests for a large error and
// finishes the anti-windup decay of the integral.
// ----------------------------------------------------------------------------
module rbpgt_scale import rbpgt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  front_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output scale_t out_data
);

	logic        vld_s3;
	scale_t      data_s3;
	scale_t      nxt;
	logic [28:0] n_kp_up;
	logic [28:0] n_ki_up;
	logic [28:0] n_kp_dn;
	logic [28:0] n_kd_up;
	logic [18:0] q_kp_up;
	logic [18:0] q_ki_up;
	logic [18:0] q_kp_dn;
	logic [18:0] q_kd_up;
	logic [23:0] err_mag;
	logic [26:0] lhs;
	logic [26:0] rhs;
	logic [47:0] rnd;
	logic [31:0] dec_mag;

	assign in_ready  = ~vld_s3 | out_ready;
	assign out_valid = vld_s3;
	assign out_data  = data_s3;

	always_comb begin
		// Numerators are the rounded step formulas brought to a common divisor of 1250.
		n_kp_up = 29'({in_data.dt, 11'b0}) + 29'({in_data.dt, 10'b0}) + 29'(RND_1250);
		n_ki_up = 29'({in_data.dt, 10'b0}) + 29'(RND_1250);
		n_kp_dn = 29'({in_data.dt, 12'b0}) + 29'({in_data.dt, 10'b0}) + 29'(RND_1250);
		n_kd_up = 29'({in_data.dt, 11'b0}) + 29'(RND_1250);
		q_kp_up = div1250(n_kp_up);
		q_ki_up = div1250(n_ki_up);
		q_kp_dn = div1250(n_kp_dn);
		q_kd_up = div1250(n_kd_up);

		err_mag = in_data.err[24] ? 24'(-in_data.err) : 24'(in_data.err);
		lhs = 27'({err_mag, 2'b00}) + 27'(err_mag);
		rhs = 27'({in_data.sp_mag, 1'b0}) + ERR_OFFSET;

		rnd     = in_data.int_prod + DECAY_ROUND;
		dec_mag = rnd[47:16];

		nxt.tune    = in_data.tune;
		nxt.err     = in_data.err;
		nxt.big_err = lhs > rhs;
		nxt.kp_up   = q_kp_up[17:0];
		nxt.ki_up   = q_ki_up[15:0];
		nxt.kp_dn   = q_kp_dn;
		nxt.kd_up   = q_kd_up[16:0];
		if (in_data.tune && in_data.sat) begin
			nxt.integral = in_data.int_neg ? -$signed(dec_mag) : $signed(dec_mag);
		end else begin
			nxt.integral = in_data.integral;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (in_ready) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3 <= nxt;
		end
	end

endmodule

### hdl/rbpgt_adapt.sv
// ----------------------------------------------------------------------------
// Tuner adapt stage
// Holds the gains and the oscillation count, applies the tuning rules
// and drives the result register.
// ----------------------------------------------------------------------------
module rbpgt_adapt import rbpgt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_ready,
	input  scale_t  in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic [13:0]        kp_q;
	logic [12:0]        ki_q;
	logic [10:0]        kd_q;
	logic signed [24:0] prev_err_q;
	logic [2:0]         flips_q;
	logic               res_vld_q;
	result_t            res_q;

	logic               e_pos;
	logic               e_neg;
	logic               p_pos;
	logic               p_neg;
	logic [2:0]         flips_inc;
	logic               hit;
	logic [2:0]         flips_nxt;
	logic signed [20:0] kp_sum;
	logic [16:0]        ki_sum;
	logic [16:0]        kd_sum;
	logic [13:0]        kp_new;
	logic [12:0]        ki_new;
	logic [10:0]        kd_new;
	result_t            nxt;

	assign in_ready  = ~res_vld_q | out_ready;
	assign out_valid = res_vld_q;
	assign out_data  = res_q;

	always_comb begin
		e_pos = !in_data.err[24] && (in_data.err != '0);
		e_neg = in_data.err[24];
		p_pos = !prev_err_q[24] && (prev_err_q != '0);
		p_neg = prev_err_q[24];

		if ((e_pos && p_neg) || (e_neg && p_pos)) begin
			flips_inc = flips_q + 3'd1;
		end else if (flips_q != '0) begin
			flips_inc = flips_q - 3'd1;
		end else begin
			flips_inc = flips_q;
		end
		hit       = flips_inc >= FLIP_LIMIT;
		flips_nxt = hit ? 3'd0 : flips_inc;

		kp_sum = $signed({7'b0, kp_q})
			+ (in_data.big_err ? $signed({3'b0, in_data.kp_up}) : 21'sd0)
			- (hit ? $signed({2'b0, in_data.kp_dn}) : 21'sd0);
		ki_sum = {4'b0, ki_q} + (in_data.big_err ? {1'b0, in_data.ki_up} : 17'd0);
		kd_sum = {6'b0, kd_q} + (hit ? in_data.kd_up : 17'd0);

		if (kp_sum[20] || kp_sum[19:0] < 20'(KP_MIN)) begin
			kp_new = KP_MIN;
		end else if (kp_sum[19:0] > 20'(KP_MAX)) begin
			kp_new = KP_MAX;
		end else begin
			kp_new = kp_sum[13:0];
		end
		ki_new = (ki_sum > 17'(KI_MAX)) ? KI_MAX : ki_sum[12:0];
		kd_new = (kd_sum > 17'(KD_MAX)) ? KD_MAX : kd_sum[10:0];

		nxt.integral_out = in_data.integral;
		if (in_data.tune) begin
			nxt.kp_out     = kp_new;
			nxt.ki_out     = ki_new;
			nxt.kd_out     = kd_new;
			nxt.flip_count = flips_nxt;
		end else begin
			nxt.kp_out     = kp_q;
			nxt.ki_out     = ki_q;
			nxt.kd_out     = kd_q;
			nxt.flip_count = flips_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q       <= KP_RESET;
			ki_q       <= KI_RESET;
			kd_q       <= KD_RESET;
			prev_err_q <= '0;
			flips_q    <= '0;
			res_vld_q  <= 1'b0;
		end else begin
			if (in_ready) begin
				res_vld_q <= in_valid;
			end
			if (in_valid && in_ready && in_data.tune) begin
				kp_q       <= kp_new;
				ki_q       <= ki_new;
				kd_q       <= kd_new;
				prev_err_q <= in_data.err;
				flips_q    <= flips_nxt;
			end else if (cfg.write) begin
				// A start value loads its gain, clamped to the safe range, unless a tuning tick is taken.
				unique case (cfg.index)
					REG_KP_START: begin
						if (cfg.data < KP_MIN) begin
							kp_q <= KP_MIN;
						end else if (cfg.data > KP_MAX) begin
							kp_q <= KP_MAX;
						end else begin
							kp_q <= cfg.data;
						end
					end
					REG_KI_START: begin
						ki_q <= (cfg.data[12:0] > KI_MAX) ? KI_MAX : cfg.data[12:0];
					end
					REG_KD_START: begin
						kd_q <= (cfg.data[10:0] > KD_MAX) ? KD_MAX : cfg.data[10:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= nxt;
		end
	end

endmodule

### hdl/rule_based_pid_gain_tuner_unit.sv
// ----------------------------------------------------------------------------
// Rule-based PID gain tuner
// Adapts kp, ki and kd from the speed error and oscillation; decays the integral on saturation.
// ----------------------------------------------------------------------------
// Pipeline: a transaction passes through the input register and then the front,
// scale and adapt stages before its result shows on the output.
// Throughput: one transaction per cycle; each stage stalls only on the one after it.
// Reset: pipeline empty, gains 4096/2048/0, no previous tick, flip count zero.
module rule_based_pid_gain_tuner_unit import rbpgt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tick_t                 in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output result_t               out_data,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic   vld_s1;
	tick_t  data_s1;
	logic   front_ready;
	logic   front_valid;
	front_t front_data;
	logic   scale_ready;
	logic   scale_valid;
	scale_t scale_data;
	logic   adapt_ready;
	cfg_t   cfg;

	assign in_ready = ~vld_s1 | front_ready;

	assign cfg.write = cfg_write;
	assign cfg.index = cfg_reg_t'(cfg_index);
	assign cfg.data  = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	rbpgt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (front_ready),
		.in_data   (data_s1),
		.out_valid (front_valid),
		.out_ready (scale_ready),
		.out_data  (front_data)
	);

	rbpgt_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (scale_ready),
		.in_data   (front_data),
		.out_valid (scale_valid),
		.out_ready (adapt_ready),
		.out_data  (scale_data)
	);

	rbpgt_adapt u_adapt (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (scale_valid),
		.in_ready  (adapt_ready),
		.in_data   (scale_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### hdl/rbpgt_checker.sv
// ----------------------------------------------------------------------------
// Rule-based PID gain tuner checker
// Port-level assertions on the tuner, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rbpgt_checker import rbpgt_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input tick_t                 in_data,
	input logic                  out_valid,
	input logic                  out_ready,
	input result_t               out_data,
	input logic                  cfg_write,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// A stalled result transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// With no result pending, every stage is free to move.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output");

	// The count is cleared whenever it reaches the limit.
	a_flip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.flip_count < FLIP_LIMIT)
		else $error("flip count at or above limit");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.kp_out >= KP_MIN && out_data.kp_out <= KP_MAX
			&& out_data.ki_out <= KI_MAX && out_data.kd_out <= KD_MAX)
		else $error("gain outside its clamp range");

	// The user must send a configuration write only with the pipeline idle (not enforced
	// by the design): no input transaction taken in the same cycle and no result waiting.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |-> !(in_valid && in_ready) && !out_valid)
		else $error("configuration write while the pipeline is busy");

endmodule

bind rule_based_pid_gain_tuner_unit rbpgt_checker u_rbpgt_checker (.*);

### verif/tb_rule_based_pid_gain_tuner_unit.sv
// ----------------------------------------------------------------------------
// Gain tuner unit testbench
// Drives control ticks and register writes into the tuner and checks every
// result against a cycle-free model of the gain adaptation rules kept here.
// ----------------------------------------------------------------------------
module tb_rule_based_pid_gain_tuner_unit;
	import rbpgt_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 80;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	class tuner_scoreboard;
		int kp_gain, ki_gain, kd_gain;
		logic [31:0] last_ms;
		longint prev_err;
		int flips;
		result_t due[$];
		int ticks, tuning, boosts, backoffs, decays, settings;
		int checked, failures, reported;

		function new();
			kp_gain = KP_RESET;
			ki_gain = KI_RESET;
			kd_gain = KD_RESET;
			last_ms = '0;
			prev_err = 0;
			flips = 0;
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function int pending();
			return due.size();
		endfunction

		// A start register write reloads the live gain, clamped to its range.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_KP_START: kp_gain = int'(clamp(longint'(val), KP_MIN, KP_MAX));
				REG_KI_START: ki_gain = int'(clamp(longint'(val[12:0]), 0, KI_MAX));
				REG_KD_START: kd_gain = int'(clamp(longint'(val[10:0]), 0, KD_MAX));
				default: ;
			endcase
		endfunction

		function void note_tick(tick_t t);
			result_t want;
			logic [31:0] delta;
			longint dt, sum, avg, sp, err, err_mag, sp_mag, kp, ki, kd, integ, mag;
			longint dl, dr;
			ticks++;
			integ = longint'(t.integral_in);
			if (t.speed_mode) begin
				tuning++;
				if (last_ms == 0) begin
					dt = 20;
				end else begin
					delta = t.timestamp_ms - last_ms;
					dt = (delta == 0) ? 20 : ((delta > 32'd65535) ? 65535 : longint'(delta));
				end
				last_ms = t.timestamp_ms;

				sum = longint'(t.wheel_speed_left) + longint'(t.wheel_speed_right);
				avg = sum >>> 1;
				sp = longint'(t.target_speed);
				err = sp - avg;

				if ((err > 0 && prev_err < 0) || (err < 0 && prev_err > 0))
					flips++;
				else if (flips > 0)
					flips--;

				kp = kp_gain;
				ki = ki_gain;
				kd = kd_gain;
				err_mag = err < 0 ? -err : err;
				sp_mag = sp < 0 ? -sp : sp;
				if (5 * err_mag > 2 * sp_mag + 12800) begin
					boosts++;
					kp += (dt * 12288 + 2500) / 5000;
					ki += (dt * 4096 + 2500) / 5000;
				end
				if (flips >= FLIP_LIMIT) begin
					backoffs++;
					kp -= (dt * 4096 + 500) / 1000;
					kd += (dt * 8192 + 2500) / 5000;
					flips = 0;
				end

				dl = longint'(t.drive_left);
				dr = longint'(t.drive_right);
				if (dl >= 255 || dl <= -255 || dr >= 255 || dr <= -255) begin
					decays++;
					mag = integ < 0 ? -integ : integ;
					mag = (mag * 64225 + 32768) >>> 16;
					integ = integ < 0 ? -mag : mag;
				end

				kp_gain = int'(clamp(kp, KP_MIN, KP_MAX));
				ki_gain = int'(clamp(ki, 0, KI_MAX));
				kd_gain = int'(clamp(kd, 0, KD_MAX));
				prev_err = err;
			end
			want.kp_out = 14'(kp_gain);
			want.ki_out = 13'(ki_gain);
			want.kd_out = 11'(kd_gain);
			want.integral_out = 32'(integ);
			want.flip_count = 3'(flips);
			due.push_back(want);
		endfunction

		function void check_result(result_t got);
			result_t want;
			checked++;
			if (due.size() == 0) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("Result with nothing outstanding: kp=%0d ki=%0d kd=%0d int=%0d flips=%0d",
						got.kp_out, got.ki_out, got.kd_out, got.integral_out, got.flip_count);
				end
				return;
			end
			want = due.pop_front();
			if (got.kp_out !== want.kp_out || got.ki_out !== want.ki_out ||
					got.kd_out !== want.kd_out || got.integral_out !== want.integral_out ||
					got.flip_count !== want.flip_count) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("Result %0d differs: expected kp=%0d ki=%0d kd=%0d int=%0d flips=%0d",
						checked, want.kp_out, want.ki_out, want.kd_out, want.integral_out,
						want.flip_count);
					$display("  got kp=%0d ki=%0d kd=%0d int=%0d flips=%0d",
						got.kp_out, got.ki_out, got.kd_out, got.integral_out, got.flip_count);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	tick_t in_data;
	logic out_valid;
	logic out_ready;
	result_t out_data;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bit tx_steady;
	bit rx_steady;
	bit stall_req;
	logic [31:0] clock_ms;
	bit osc_neg;

	tuner_scoreboard sb = new();

	rule_based_pid_gain_tuner_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic tick_t mk(logic [31:0] ts, logic mode, int l, int r, int sp,
			int dl, int dr, int integ);
		tick_t t;
		t.timestamp_ms = ts;
		t.speed_mode = mode;
		t.wheel_speed_left = 24'(l);
		t.wheel_speed_right = 24'(r);
		t.target_speed = 24'(sp);
		t.drive_left = 16'(dl);
		t.drive_right = 16'(dr);
		t.integral_in = integ;
		return t;
	endfunction

	// Mostly well-formed ticks: advancing time, a steered error that tends to
	// alternate in sign, and drive commands near the saturation level.
	function automatic tick_t random_tick();
		tick_t t;
		int pick, sp, err, mag, mid, spread;
		pick = $urandom_range(99);
		if (pick < 20) begin
			t.timestamp_ms = $urandom;
			t.speed_mode = (pick < 12) ? 1'($urandom) : 1'b0;
			t.wheel_speed_left = 24'($urandom);
			t.wheel_speed_right = 24'($urandom);
			t.target_speed = 24'($urandom);
			t.drive_left = 16'($urandom);
			t.drive_right = 16'($urandom);
			t.integral_in = $urandom;
			return t;
		end

		pick = $urandom_range(99);
		if (pick < 70)
			clock_ms += $urandom_range(40, 1);
		else if (pick >= 78 && pick < 88)
			clock_ms += $urandom_range(300000, 65536);
		else if (pick >= 88 && pick < 94)
			clock_ms -= $urandom_range(1000, 1);
		else if (pick >= 94 && pick < 97)
			clock_ms = '0;
		else if (pick >= 97)
			clock_ms = $urandom;

		sp = $urandom_range(1) ? int'($urandom_range(8000000)) - 4000000
			: int'($urandom_range(40000)) - 20000;
		pick = $urandom_range(99);
		mag = (pick < 10) ? 0 : ((pick < 55) ? int'($urandom_range(2560))
			: int'($urandom_range(2000000)));
		if ($urandom_range(99) < 70)
			osc_neg = !osc_neg;
		err = osc_neg ? -mag : mag;
		mid = sp - err;
		spread = int'($urandom_range(4000000)) - 2000000;

		t.timestamp_ms = clock_ms;
		t.speed_mode = 1'b1;
		t.wheel_speed_left = 24'(mid + spread);
		t.wheel_speed_right = 24'(mid - spread);
		t.target_speed = 24'(sp);
		t.drive_left = ($urandom_range(99) < 75) ? 16'(int'($urandom_range(600)) - 300)
			: 16'($urandom);
		t.drive_right = ($urandom_range(99) < 75) ? 16'(int'($urandom_range(600)) - 300)
			: 16'($urandom);
		t.integral_in = $urandom;
		return t;
	endfunction

	task automatic send_tick(input tick_t t);
		if (!tx_steady) begin
			while ($urandom_range(99) < 33) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_tick(t);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] kp, input logic [CFG_DATA_W-1:0] ki,
			input logic [CFG_DATA_W-1:0] kd);
		put_reg(REG_KP_START, kp);
		put_reg(REG_KI_START, ki);
		put_reg(REG_KD_START, kd);
		put_reg(REG_NONE, 14'($urandom));
		cfg_write <= 1'b0;
		@(posedge clk);
		sb.settings++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int count);
		repeat (count) send_tick(random_tick());
	endtask

	task automatic run_directed();
		send_tick(mk(1000, 0, -8388608, 8388607, 0, -32768, 32767, 32'sh8000_0000));
		// A zero timestamp is a tick like any other but still reads as no tick yet.
		send_tick(mk(0, 1, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF));
		send_tick(mk(0, 1, -8388608, -8388608, 8388607, 255, 0, 32'sh7FFF_FFFF));
		send_tick(mk(5, 1, 8388607, 8388607, -8388608, -255, 0, 32'sh8000_0000));
		send_tick(mk(5, 1, -8388608, -8388608, 8388607, -32768, 0, -1));
		send_tick(mk(30, 1, 8388607, 8388607, -8388608, 254, -254, 12345));
		send_tick(mk(100000, 1, -8388608, -8388608, 8388607, 0, 32767, -1000));
		send_tick(mk(50, 1, 0, 0, 0, 0, -32768, 1));
		// Errors on either side of the large-error threshold with a zero setpoint.
		send_tick(mk(70, 1, -2560, -2560, 0, 0, 0, 0));
		send_tick(mk(90, 1, 2561, 2561, 0, 0, 0, 0));
		send_tick(mk(91, 1, 1, 0, 0, 0, 0, 0));
		send_tick(mk(92, 1, -1, 0, 0, 0, 0, 0));
		send_tick(mk(200000, 1, -8388608, -8388608, 8388607, 0, 0, 7));
		send_tick(mk(300000, 1, 0, 0, -100000, 0, 0, 0));
		send_tick(mk(400000, 1, 0, 0, 100000, 0, 0, 0));
		send_tick(mk(500000, 1, 0, 0, -100000, 0, 0, 0));
		send_tick(mk(600000, 1, 0, 0, 100000, 0, 0, 0));
		send_tick(mk(0, 0, 8388607, 8388607, 8388607, 32767, 32767, 32'sh7FFF_FFFF));
		send_tick(mk(32'hFFFF_FFFF, 1, 8388607, -8388608, 0, 32767, -32768, 32'sh8000_0000));
		send_tick(mk(3, 1, 1000, 3000, -500, -256, 255, -65536));
	endtask

	initial begin : stimulus
		in_valid = 1'b0;
		in_data = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		stall_req = 1'b0;
		clock_ms = 32'd1;
		osc_neg = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random(250);
		drain();

		// Lowest settings; the receiver stalls for a long stretch while ticks keep coming.
		configure(14'd0, 14'd0, 14'd0);
		tx_steady = 1'b1;
		stall_req = 1'b1;
		run_random(250);
		drain();

		// All register bits set, so every gain loads clamped at its top.
		configure(14'h3FFF, 14'h3FFF, 14'h3FFF);
		rx_steady = 1'b1;
		run_random(250);
		drain();

		configure(14'($urandom_range(10240, 1229)), 14'($urandom_range(4915)),
			14'($urandom_range(1638)));
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		run_random(250);
		drain();

		$display("Ran %0d ticks (%0d tuning) under %0d register settings plus reset values.",
			sb.ticks, sb.tuning, sb.settings);
		$display("Saw %0d error boosts, %0d oscillation back-offs, %0d integral decays; %0d bad.",
			sb.boosts, sb.backoffs, sb.decays, sb.failures);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : result_side
		int hold_left;
		out_ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result(out_data);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_req) begin
				stall_req = 1'b0;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= rx_steady || ($urandom_range(99) >= 33);
			end
		end
	end

	initial begin : watchdog
		#(LIMIT_CYCLES * 10);
		$display("Run timed out with %0d results outstanding.", sb.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
hdl/rbpgt_pkg.sv
hdl/rbpgt_front.sv
hdl/rbpgt_scale.sv
hdl/rbpgt_adapt.sv
hdl/rule_based_pid_gain_tuner_unit.sv
hdl/rbpgt_checker.sv
verif/tb_rule_based_pid_gain_tuner_unit.sv
